// ===== hw/rtl/word_tokenizer_fnv1a_hasher_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the word tokenizer
// Clocked on clk and disabled during rst; the including module names both.
// ----------------------------------------------------------------------------
`ifndef WORD_TOKENIZER_FNV1A_HASHER_TOP_MACROS_SVH
`define WORD_TOKENIZER_FNV1A_HASHER_TOP_MACROS_SVH

// same-cycle implication
`define WTOK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WTOK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/wtok_pkg.sv =====
// ----------------------------------------------------------------------------
// wtok_pkg
// Types and constants for the whitespace tokenizer with FNV-1a hashing.
// ----------------------------------------------------------------------------
package wtok_pkg;

  localparam int unsigned LENGTH_WIDTH_DEF = 16;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  localparam logic [7:0] CHR_NUL = 8'h00;
  localparam logic [7:0] CHR_TAB = 8'h09;
  localparam logic [7:0] CHR_LF  = 8'h0A;
  localparam logic [7:0] CHR_VT  = 8'h0B;
  localparam logic [7:0] CHR_FF  = 8'h0C;
  localparam logic [7:0] CHR_CR  = 8'h0D;
  localparam logic [7:0] CHR_SP  = 8'h20;

  localparam logic [15:0] EOS_LENGTH = 16'd4;

  // result queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } byte_t;

  typedef struct packed {
    logic [31:0] word_hash;
    logic [15:0] word_length;
    logic        is_eos;
    logic        last;
  } token_t;

  // one FNV-1a step, byte sign-extended before the xor
  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] v;
    v = {{24{b[7]}}, b};
    return (h ^ v) * FNV_PRIME;
  endfunction

  function automatic logic [31:0] eos_hash_calc();
    logic [31:0] h;
    h = FNV_BASIS;
    h = fnv_mix(h, 8'h3C); // '<'
    h = fnv_mix(h, 8'h2F); // '/'
    h = fnv_mix(h, 8'h73); // 's'
    h = fnv_mix(h, 8'h3E); // '>'
    return h;
  endfunction

  localparam logic [31:0] EOS_HASH = eos_hash_calc();

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CHR_SP, CHR_LF, CHR_CR, CHR_TAB, CHR_VT, CHR_FF, CHR_NUL};
  endfunction

endpackage

// ===== hw/rtl/word_tokenizer_fnv1a_hasher_top.sv =====
// ----------------------------------------------------------------------------
// word_tokenizer_fnv1a_hasher_top
// Splits a byte stream into words and emits FNV-1a hash and length per word.
// ----------------------------------------------------------------------------
// A byte is taken on every cycle while the four-entry result queue has room
// for two tokens. Word bytes are folded into the running hash (one xor and
// one constant multiply) in the cycle they transfer; a whitespace byte or
// end_of_input writes the finished word, and for a newline also the "</s>"
// token, into the queue, which the token port reads in order. The token port
// drains one entry per cycle while token_ready is high; a newline that ends a
// word adds two entries, while other bytes sustain one byte per cycle.
// Lengths saturate at 2**LENGTH_WIDTH-1 and are reported in 16 bits.
module word_tokenizer_fnv1a_hasher_top
  import wtok_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   byte_valid,
  output logic   byte_ready,
  input  byte_t  byte_data,
  output logic   token_valid,
  input  logic   token_ready,
  output token_t token_data
);

`include "word_tokenizer_fnv1a_hasher_top_macros.svh"

  logic                    inside_word;
  logic [31:0]             running_hash;
  logic [LENGTH_WIDTH-1:0] byte_count;

  token_t                  queue [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr;
  logic [QUEUE_PTR_W-1:0]  rd_ptr;
  logic [QUEUE_CNT_W-1:0]  queue_count;
  logic [QUEUE_CNT_W-1:0]  queue_count_next;

  logic       byte_xfer;
  logic       token_xfer;
  logic       space;
  logic       newline;
  logic       word_done;
  logic       eos_emit;
  logic [1:0] push_n;
  token_t     word_tok;
  token_t     eos_tok;
  token_t     first_tok;

  assign byte_ready  = (queue_count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
  assign byte_xfer   = byte_valid && byte_ready;
  assign token_valid = (queue_count != '0);
  assign token_xfer  = token_valid && token_ready;
  assign token_data  = queue[rd_ptr];

  always_comb begin
    space     = is_space(byte_data.data_byte);
    newline   = !byte_data.end_of_input && (byte_data.data_byte == CHR_LF);
    word_done = inside_word && (byte_data.end_of_input || space);
    eos_emit  = newline;

    word_tok.word_hash   = running_hash;
    word_tok.word_length = 16'(byte_count);
    word_tok.is_eos      = 1'b0;
    word_tok.last        = !newline;

    eos_tok.word_hash   = EOS_HASH;
    eos_tok.word_length = EOS_LENGTH;
    eos_tok.is_eos      = 1'b1;
    eos_tok.last        = 1'b1;

    first_tok = word_done ? word_tok : eos_tok;
    push_n    = byte_xfer ? (2'(word_done) + 2'(eos_emit)) : 2'd0;

    queue_count_next = queue_count + QUEUE_CNT_W'(push_n) - QUEUE_CNT_W'(token_xfer);
  end

  // word state; the cleared state is also what an idle tokenizer holds
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_word  <= 1'b0;
      running_hash <= FNV_BASIS;
      byte_count   <= '0;
    end else if (byte_xfer) begin
      if (byte_data.end_of_input || space) begin
        inside_word  <= 1'b0;
        running_hash <= FNV_BASIS;
        byte_count   <= '0;
      end else begin
        inside_word  <= 1'b1;
        running_hash <= fnv_mix(running_hash, byte_data.data_byte);
        if (byte_count != '1) begin
          byte_count <= byte_count + LENGTH_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      queue_count <= '0;
    end else begin
      wr_ptr      <= wr_ptr + QUEUE_PTR_W'(push_n);
      rd_ptr      <= rd_ptr + QUEUE_PTR_W'(token_xfer);
      queue_count <= queue_count_next;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= first_tok;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + QUEUE_PTR_W'(1)] <= eos_tok;
    end
  end

  `WTOK_ASSERT_SAME(a_queue_bound, 1'b1, queue_count <= QUEUE_CNT_W'(QUEUE_DEPTH),
    "result queue overflow")
  `WTOK_ASSERT_SAME(a_idle_clear, !inside_word,
    (running_hash == FNV_BASIS) && (byte_count == '0),
    "word state not cleared outside a word")
  `WTOK_ASSERT_NEXT(a_eoi_clears, byte_xfer && byte_data.end_of_input, !inside_word,
    "end of input did not clear word state")

endmodule

// ===== tb/tb_word_tokenizer_fnv1a_hasher_top.sv =====
// ----------------------------------------------------------------------------
// tb_word_tokenizer_fnv1a_hasher_top
// Drives byte streams into the word tokenizer and checks every token against
// a built-in tokenizer/FNV-1a predictor: word hash, saturating length, the
// end-of-sentence token and the last flag. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_word_tokenizer_fnv1a_hasher_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wtok_pkg::*;

  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 950;
  localparam int LONG_WORD_BYTES = 64;

  // Predicts tokens from accepted bytes and checks them in order.
  class token_scoreboard;
    bit in_word;
    logic [31:0] word_hash_acc;
    longint unsigned word_len;
    longint unsigned len_cap;
    logic [31:0] sentence_end_hash;
    token_t expected_tokens[$];
    int mismatches;

    function new();
      len_cap = (64'd1 << LENGTH_WIDTH_DEF) - 1;
      mismatches = 0;
      sentence_end_hash = FNV_BASIS;
      sentence_end_hash = fold_byte(sentence_end_hash, "<");
      sentence_end_hash = fold_byte(sentence_end_hash, "/");
      sentence_end_hash = fold_byte(sentence_end_hash, "s");
      sentence_end_hash = fold_byte(sentence_end_hash, ">");
      clear_word();
    endfunction

    static function logic [31:0] fold_byte(logic [31:0] h, logic [7:0] c);
      logic [31:0] wide;
      wide = {{24{c[7]}}, c};  // signed char semantics
      return (h ^ wide) * FNV_PRIME;
    endfunction

    static function bit is_blank(logic [7:0] c);
      case (c)
        CHR_SP, CHR_LF, CHR_CR, CHR_TAB, CHR_VT, CHR_FF, CHR_NUL: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void clear_word();
      in_word = 1'b0;
      word_hash_acc = FNV_BASIS;
      word_len = 0;
    endfunction

    function void push_token(logic [31:0] h, longint unsigned len, bit eos, bit fin);
      token_t t;
      t.word_hash = h;
      t.word_length = len[15:0];
      t.is_eos = eos;
      t.last = fin;
      expected_tokens = {expected_tokens, t};
    endfunction

    function void note_byte(byte_t b);
      bit newline;
      if (b.end_of_input) begin
        if (in_word) push_token(word_hash_acc, word_len, 1'b0, 1'b1);
        clear_word();
        return;
      end
      if (is_blank(b.data_byte)) begin
        newline = (b.data_byte == CHR_LF);
        if (in_word) begin
          push_token(word_hash_acc, word_len, 1'b0, !newline);
          clear_word();
        end
        if (newline) push_token(sentence_end_hash, 64'(EOS_LENGTH), 1'b1, 1'b1);
        return;
      end
      word_hash_acc = fold_byte(word_hash_acc, b.data_byte);
      if (word_len < len_cap) word_len++;
      in_word = 1'b1;
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: word_hash %h word_length %0d is_eos %0b last %0b",
               got.word_hash, got.word_length, got.is_eos, got.last);
        mismatches++;
        return;
      end
      want = expected_tokens.pop_front();
      if (got.word_hash !== want.word_hash) begin
        $error("word_hash: expected %h, got %h", want.word_hash, got.word_hash);
        mismatches++;
      end
      if (got.word_length !== want.word_length) begin
        $error("word_length: expected %0d, got %0d", want.word_length, got.word_length);
        mismatches++;
      end
      if (got.is_eos !== want.is_eos) begin
        $error("is_eos: expected %0b, got %0b", want.is_eos, got.is_eos);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic   clk;
  logic   rst = 1'b1;
  logic   byte_valid = 1'b0;
  logic   byte_ready;
  byte_t  byte_data = '0;
  logic   token_valid;
  logic   token_ready = 1'b0;
  token_t token_data;

  token_scoreboard sb = new();
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  int bytes_sent = 0;
  int cycle_count = 0;

  word_tokenizer_fnv1a_hasher_top uut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .token_valid(token_valid),
    .token_ready(token_ready),
    .token_data (token_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_word_tokenizer_fnv1a_hasher_top failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && token_valid === 1'b1 && token_ready) sb.check_token(token_data);
  end

  // token receiver: random stall per token, one long hold on request
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        stall = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 6);
      end
      repeat (stall) begin
        token_ready <= 1'b0;
        @(posedge clk);
      end
      token_ready <= 1'b1;
      do @(posedge clk); while (token_valid !== 1'b1);
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic eoi);
    byte_t b;
    int gap;
    b.data_byte = c;
    b.end_of_input = eoi;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= b;
    do @(posedge clk); while (byte_ready !== 1'b1);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (token_scoreboard::is_blank(c));
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return CHR_SP;
      3, 4, 5: return CHR_LF;
      6:       return CHR_CR;
      7:       return CHR_TAB;
      8:       return CHR_VT;
      default: return $urandom_range(0, 1) ? CHR_FF : CHR_NUL;
    endcase
  endfunction

  initial begin
    int rand_base;
    int pick;
    int len;
    bit hold_done;
    bit drain_done;
    hold_done = 1'b0;
    drain_done = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: skipped leading blanks, bare newline, every separator,
    // sign-extended high bytes, flush with and without a pending word
    send_byte(CHR_SP, 1'b0);
    send_byte(CHR_TAB, 1'b0);
    send_byte(CHR_LF, 1'b0);
    send_byte("a", 1'b0);
    send_byte(CHR_LF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(CHR_CR, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(CHR_VT, 1'b0);
    send_byte("z", 1'b0);
    send_byte(CHR_FF, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(CHR_NUL, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte("w", 1'b0);
    send_byte(CHR_LF, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte("b", 1'b0);
    send_byte(CHR_SP, 1'b0);
    send_byte(CHR_SP, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CHR_TAB, 1'b0);

    // one long word, streamed back to back
    no_gaps = 1'b1;
    repeat (LONG_WORD_BYTES) send_byte(word_char(), 1'b0);
    send_byte(CHR_LF, 1'b0);
    no_gaps = 1'b0;

    rand_base = bytes_sent;
    while (bytes_sent < rand_base + RANDOM_BYTES) begin
      if (!hold_done && bytes_sent >= rand_base + 250) begin
        hold_done = 1'b1;
        hold_req = 1'b1;
      end
      if (!drain_done && bytes_sent >= rand_base + 550) begin
        drain_done = 1'b1;
        wait_drained();
      end
      no_gaps = (bytes_sent >= rand_base + 750) && (bytes_sent < rand_base + 850);
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        repeat (len) send_byte(word_char(), 1'b0);
        repeat ($urandom_range(1, 2)) send_byte(blank_char(), 1'b0);
      end else if (pick < 88) begin
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 6)) send_byte(word_char(), 1'b0);
        send_byte(8'($urandom), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'($urandom));
      end
    end
    no_gaps = 1'b0;
    send_byte("e", 1'b0);
    send_byte(8'h00, 1'b1);
    byte_valid <= 1'b0;

    wait_drained();
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_tokens.size() == 0) begin
      $display("tb_word_tokenizer_fnv1a_hasher_top passed");
    end else begin
      $display("tb_word_tokenizer_fnv1a_hasher_top failed");
    end
    $finish;
  end

endmodule

// ===== word_tokenizer_fnv1a_hasher_top.f =====
+incdir+hw/rtl
hw/rtl/wtok_pkg.sv
hw/rtl/word_tokenizer_fnv1a_hasher_top.sv
tb/tb_word_tokenizer_fnv1a_hasher_top.sv
